// ----- rtl/etf_pkg.sv -----
// ----------------------------------------------------------------------------
// etf_pkg: shared constants for the exponential tail filter
// Register indexes, fixed coefficient widths and mode codes.
// ----------------------------------------------------------------------------
package etf_pkg;

  // Fixed coefficient widths
  localparam int BETA_BITS    = 16;
  localparam int ALPHA_BITS   = 24;
  // Guard bits of the internal tail/signal range over the sample range
  localparam int GUARD_BITS   = 4;
  // Configuration index width
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BETA      = 2'd0,
    REG_ALPHA     = 2'd1,
    REG_PEDESTAL  = 2'd2,
    REG_INIT_TAIL = 2'd3
  } cfg_reg_t;

  // Mode codes
  localparam logic MODE_REMOVE = 1'b0;
  localparam logic MODE_ADD    = 1'b1;

endpackage

// ----- rtl/etf_sample_if.sv -----
// ----------------------------------------------------------------------------
// etf_sample_if: input sample channel
// Valid/ready channel carrying one waveform sample and its flags.
// ----------------------------------------------------------------------------
interface etf_sample_if #(
  parameter int SAMPLE_BITS = 20
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          mode;
  logic                          first_of_record;

  modport source (output valid, sample_value, mode, first_of_record, input ready);
  modport sink   (input valid, sample_value, mode, first_of_record, output ready);
endinterface

// ----- rtl/etf_result_if.sv -----
// ----------------------------------------------------------------------------
// etf_result_if: result channel
// Valid/ready channel carrying the corrected value, the tail and a clip flag.
// ----------------------------------------------------------------------------
interface etf_result_if #(
  parameter int SAMPLE_BITS = 20
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] result_value;
  logic signed [SAMPLE_BITS-1:0] tail_value;
  logic                          saturated;

  modport source (output valid, result_value, tail_value, saturated, input ready);
  modport sink   (input valid, result_value, tail_value, saturated, output ready);
endinterface

// ----- rtl/etf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// etf_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface etf_cfg_if
  import etf_pkg::*;
#(
  parameter int DATA_BITS = 24
);
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [DATA_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/etf_datapath.sv -----
// ----------------------------------------------------------------------------
// etf_datapath: tail recurrence and correction for one sample
// Two products, rounded sum, tail/signal update and output saturation.
// ----------------------------------------------------------------------------
module etf_datapath
  import etf_pkg::*;
#(
  parameter int SAMPLE_BITS     = 20,
  parameter int COEFF_FRAC_BITS = 16
) (
  input  logic                                     mode,
  input  logic                                     first_of_record,
  input  logic signed [SAMPLE_BITS-1:0]            sample_value,
  input  logic        [BETA_BITS-1:0]              beta_coeff,
  input  logic signed [ALPHA_BITS-1:0]             alpha_coeff,
  input  logic signed [SAMPLE_BITS-1:0]            pedestal_level,
  input  logic signed [SAMPLE_BITS-1:0]            initial_tail,
  input  logic signed [SAMPLE_BITS+GUARD_BITS-1:0] tail_acc,
  input  logic signed [SAMPLE_BITS+GUARD_BITS-1:0] prev_signal,
  output logic signed [SAMPLE_BITS+GUARD_BITS-1:0] tail_acc_next,
  output logic signed [SAMPLE_BITS+GUARD_BITS-1:0] prev_signal_next,
  output logic signed [SAMPLE_BITS-1:0]            result_value,
  output logic signed [SAMPLE_BITS-1:0]            tail_value,
  output logic                                     saturated
);

  localparam int ACC_W   = SAMPLE_BITS + GUARD_BITS;
  localparam int BPROD_W = ACC_W + BETA_BITS + 1;
  localparam int APROD_W = ACC_W + ALPHA_BITS;
  localparam int SUM_W   = APROD_W + 2;
  localparam int EXT_W   = ACC_W + 2;

  logic signed [BPROD_W-1:0] beta_prod;
  logic signed [APROD_W-1:0] alpha_prod;
  logic signed [SUM_W-1:0]   sum_raw;
  logic signed [SUM_W-1:0]   sum_shift;
  logic                      sum_fits;
  logic signed [ACC_W-1:0]   tail_rec;
  logic signed [ACC_W-1:0]   tail;
  logic signed [EXT_W-1:0]   rem_wide;
  logic signed [EXT_W-1:0]   add_wide;
  logic                      rem_fits;
  logic signed [ACC_W-1:0]   sig_rem;
  logic signed [EXT_W-1:0]   res_wide;
  logic                      res_fits;
  logic                      tail_fits;

  always_comb begin
    beta_prod  = BPROD_W'($signed({1'b0, beta_coeff})) * BPROD_W'(tail_acc);
    alpha_prod = APROD_W'(alpha_coeff) * APROD_W'(prev_signal);
    // Exact sum, add half an LSB, floor shift
    sum_raw    = SUM_W'(beta_prod) + SUM_W'(alpha_prod)
               + (SUM_W'(1) <<< (COEFF_FRAC_BITS - 1));
    sum_shift  = sum_raw >>> COEFF_FRAC_BITS;
    sum_fits   = (sum_shift[SUM_W-1:ACC_W-1] == '0) || (sum_shift[SUM_W-1:ACC_W-1] == '1);
    tail_rec   = sum_fits ? sum_shift[ACC_W-1:0]
                          : {sum_shift[SUM_W-1], {(ACC_W-1){~sum_shift[SUM_W-1]}}};
    tail       = first_of_record ? ACC_W'(initial_tail) : tail_rec;

    rem_wide   = EXT_W'(sample_value) - EXT_W'(tail) - EXT_W'(pedestal_level);
    add_wide   = EXT_W'(sample_value) + EXT_W'(tail) + EXT_W'(pedestal_level);
    rem_fits   = (rem_wide[EXT_W-1:ACC_W-1] == '0) || (rem_wide[EXT_W-1:ACC_W-1] == '1);
    sig_rem    = rem_fits ? rem_wide[ACC_W-1:0]
                          : {rem_wide[EXT_W-1], {(ACC_W-1){~rem_wide[EXT_W-1]}}};

    tail_acc_next    = tail;
    prev_signal_next = (mode == MODE_ADD) ? ACC_W'(sample_value) : sig_rem;

    // Clip both outputs to the sample range
    res_wide  = (mode == MODE_ADD) ? add_wide : EXT_W'(sig_rem);
    res_fits  = (res_wide[EXT_W-1:SAMPLE_BITS-1] == '0)
             || (res_wide[EXT_W-1:SAMPLE_BITS-1] == '1);
    tail_fits = (tail[ACC_W-1:SAMPLE_BITS-1] == '0) || (tail[ACC_W-1:SAMPLE_BITS-1] == '1);
    result_value = res_fits ? res_wide[SAMPLE_BITS-1:0]
                            : {res_wide[EXT_W-1], {(SAMPLE_BITS-1){~res_wide[EXT_W-1]}}};
    tail_value   = tail_fits ? tail[SAMPLE_BITS-1:0]
                             : {tail[ACC_W-1], {(SAMPLE_BITS-1){~tail[ACC_W-1]}}};
    saturated    = !res_fits || !tail_fits;
  end

endmodule

// ----- rtl/exponential_tail_filter.sv -----
// ----------------------------------------------------------------------------
// exponential_tail_filter: exponential undershoot tail correction
// Path: an accepted item passes through the input register, then the
//   result register.
// Throughput: one item per cycle while the result side keeps up; the tail
//   recurrence closes through the two coefficient multipliers and the state registers.
// Reset: rst (synchronous) clears the pipeline valids, the tail and
//   previous-signal state and all coefficient registers to zero.
// ----------------------------------------------------------------------------
module exponential_tail_filter
  import etf_pkg::*;
#(
  parameter int SAMPLE_BITS     = 20,
  parameter int COEFF_FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  etf_cfg_if.sink        cfg,
  etf_sample_if.sink     sample_ch,
  etf_result_if.source   result_ch
);

  localparam int ACC_W = SAMPLE_BITS + GUARD_BITS;

  // Coefficient registers
  logic        [BETA_BITS-1:0]   beta_coeff;
  logic signed [ALPHA_BITS-1:0]  alpha_coeff;
  logic signed [SAMPLE_BITS-1:0] pedestal_level;
  logic signed [SAMPLE_BITS-1:0] initial_tail;

  // Input register
  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_mode;
  logic                          in_first;

  // Recurrence state
  logic signed [ACC_W-1:0]       tail_acc;
  logic signed [ACC_W-1:0]       prev_signal;
  logic signed [ACC_W-1:0]       tail_acc_next;
  logic signed [ACC_W-1:0]       prev_signal_next;

  // Result register
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_result;
  logic signed [SAMPLE_BITS-1:0] out_tail;
  logic                          out_sat;
  logic signed [SAMPLE_BITS-1:0] result_next;
  logic signed [SAMPLE_BITS-1:0] tail_out_next;
  logic                          sat_next;

  logic                          advance;

  // Move the held item into the result register when that slot is free
  // or being emptied this cycle; the state advances with it.
  assign advance         = in_valid && (!out_valid || result_ch.ready);
  assign sample_ch.ready = !in_valid || advance;
  assign cfg.ready       = 1'b1;

  // Configuration writes; unknown indexes cannot occur with a 2-bit index
  always_ff @(posedge clk) begin
    if (rst) begin
      beta_coeff     <= '0;
      alpha_coeff    <= '0;
      pedestal_level <= '0;
      initial_tail   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BETA:      beta_coeff     <= cfg.data[BETA_BITS-1:0];
        REG_ALPHA:     alpha_coeff    <= cfg.data[ALPHA_BITS-1:0];
        REG_PEDESTAL:  pedestal_level <= cfg.data[SAMPLE_BITS-1:0];
        REG_INIT_TAIL: initial_tail   <= cfg.data[SAMPLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: hold the item until it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample_ch.ready) begin
      in_valid <= sample_ch.valid;
    end
    if (sample_ch.valid && sample_ch.ready) begin
      in_sample <= sample_ch.sample_value;
      in_mode   <= sample_ch.mode;
      in_first  <= sample_ch.first_of_record;
    end
  end

  etf_datapath #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_datapath (
    .mode             (in_mode),
    .first_of_record  (in_first),
    .sample_value     (in_sample),
    .beta_coeff       (beta_coeff),
    .alpha_coeff      (alpha_coeff),
    .pedestal_level   (pedestal_level),
    .initial_tail     (initial_tail),
    .tail_acc         (tail_acc),
    .prev_signal      (prev_signal),
    .tail_acc_next    (tail_acc_next),
    .prev_signal_next (prev_signal_next),
    .result_value     (result_next),
    .tail_value       (tail_out_next),
    .saturated        (sat_next)
  );

  // Recurrence state: advance only when the item is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_acc    <= '0;
      prev_signal <= '0;
    end else if (advance) begin
      tail_acc    <= tail_acc_next;
      prev_signal <= prev_signal_next;
    end
  end

  // Result register: hold until taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_result <= result_next;
      out_tail   <= tail_out_next;
      out_sat    <= sat_next;
    end
  end

  assign result_ch.valid        = out_valid;
  assign result_ch.result_value = out_result;
  assign result_ch.tail_value   = out_tail;
  assign result_ch.saturated    = out_sat;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: exponential tail filter check
// Drives waveform samples and coefficient writes into the filter, keeps a
// fixed-point model of the tail recurrence alongside it and compares every
// corrected value, tail and clip flag in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
  import etf_pkg::*;

  localparam int SAMPLE_W       = 20;
  localparam int FRAC_W         = 16;
  localparam int ACC_W          = SAMPLE_W + GUARD_BITS;
  localparam int CFG_W          = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_PAUSE    = 4;   // two register stages, plus margin
  localparam int HOLD_CYCLES    = 160;
  localparam int SEG_ITEMS      = 72;
  localparam int DIR_ROWS       = 36;
  localparam int MAX_REPORTS    = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t value;
    sample_t tail;
    logic    sat;
  } corrected_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of stimulus: either a coefficient write or a sample item, with
  // an optional hand-computed result.
  typedef struct packed {
    row_kind_t        kind;
    cfg_reg_t         idx;
    logic [CFG_W-1:0] data;
    sample_t          smp;
    logic             mode;
    logic             first;
    logic             typed;
    corrected_t       want;
  } stim_row_t;

  logic clk;
  logic rst;

  etf_cfg_if    #(.DATA_BITS(CFG_W))      cfg_bus ();
  etf_sample_if #(.SAMPLE_BITS(SAMPLE_W)) smp_bus ();
  etf_result_if #(.SAMPLE_BITS(SAMPLE_W)) res_bus ();

  exponential_tail_filter #(
    .SAMPLE_BITS    (SAMPLE_W),
    .COEFF_FRAC_BITS(FRAC_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_bus),
    .sample_ch(smp_bus),
    .result_ch(res_bus)
  );

  // Model copy of the coefficient registers and the recurrence state
  logic [BETA_BITS-1:0]         beta_r         = '0;
  logic signed [ALPHA_BITS-1:0] alpha_r        = '0;
  sample_t                      pedestal_r     = '0;
  sample_t                      init_tail_r    = '0;
  logic signed [ACC_W-1:0]      tail_state     = '0;
  logic signed [ACC_W-1:0]      prev_sig_state = '0;

  corrected_t corrected_q [$];   // results still owed by the filter
  stim_row_t  cur_row;           // item currently offered on the sample channel

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  logic rx_hold    = 1'b0;

  int mismatches   = 0;
  int idle_cycles  = 0;
  int items_sent   = 0;
  int records_sent = 0;
  int cfg_writes   = 0;
  int results_seen = 0;
  int clipped_seen = 0;

  // --------------------------------------------------------------------------
  // Fixed-point model
  // --------------------------------------------------------------------------
  function automatic longint clip_to(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Work out the result of one sample and advance the tail recurrence.
  function automatic corrected_t predict_tail_correction(sample_t x, logic md, logic first);
    longint     acc;
    longint     tail;
    longint     sig;
    longint     res;
    longint     res_c;
    longint     tail_c;
    corrected_t r;
    if (first) begin
      tail = longint'(init_tail_r);
    end else begin
      // exact sum, add half, floor, then hold in the guarded range
      acc = longint'(beta_r) * longint'(tail_state)
          + longint'(alpha_r) * longint'(prev_sig_state);
      acc = acc + (longint'(1) <<< (FRAC_W - 1));
      tail = clip_to(acc >>> FRAC_W, ACC_W);
    end
    if (md == MODE_ADD) begin
      sig = longint'(x);
      res = sig + tail + longint'(pedestal_r);
    end else begin
      sig = clip_to(longint'(x) - tail - longint'(pedestal_r), ACC_W);
      res = sig;
    end
    tail_state     = tail[ACC_W-1:0];
    prev_sig_state = sig[ACC_W-1:0];
    res_c  = clip_to(res, SAMPLE_W);
    tail_c = clip_to(tail, SAMPLE_W);
    r.value = res_c[SAMPLE_W-1:0];
    r.tail  = tail_c[SAMPLE_W-1:0];
    r.sat   = (res_c != res) || (tail_c != tail);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic stim_row_t cfg_row(cfg_reg_t idx, logic [CFG_W-1:0] data);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.data  = data;
    return r;
  endfunction

  function automatic stim_row_t free_row(sample_t smp, logic md, logic first);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.smp   = smp;
    r.mode  = md;
    r.first = first;
    return r;
  endfunction

  function automatic stim_row_t typed_row(sample_t smp, logic md, logic first,
                                          sample_t value, sample_t tail, logic sat);
    stim_row_t r;
    r            = free_row(smp, md, first);
    r.typed      = 1'b1;
    r.want.value = value;
    r.want.tail  = tail;
    r.want.sat   = sat;
    return r;
  endfunction

  // Mostly small values around zero, with extremes and full-range noise.
  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0:       return sample_t'(524287);
      1:       return sample_t'(-524288);
      2, 3:    return sample_t'($urandom);
      default: return sample_t'($urandom_range(8191) - 4096);
    endcase
  endfunction

  // Register value: extremes, zero or a typical setting; spare data bits random.
  function automatic logic [CFG_W-1:0] pick_reg_value(cfg_reg_t idx);
    logic [CFG_W-1:0]      noise;
    logic [BETA_BITS-1:0]  v16;
    logic [ALPHA_BITS-1:0] v24;
    logic [SAMPLE_W-1:0]   v20;
    int                    pick;
    noise = CFG_W'($urandom);
    pick  = $urandom_range(4);
    case (idx)
      REG_BETA: begin
        case (pick)
          0:       v16 = '0;
          1:       v16 = '1;
          default: v16 = BETA_BITS'($urandom_range(65535, 49152));
        endcase
        return {noise[CFG_W-1:BETA_BITS], v16};
      end
      REG_ALPHA: begin
        case (pick)
          0:       v24 = 24'h800000;
          1:       v24 = 24'h7FFFFF;
          2:       v24 = '0;
          default: v24 = ALPHA_BITS'($urandom_range(8191) - 4096);
        endcase
        return v24;
      end
      default: begin
        case (pick)
          0:       v20 = 20'h80000;
          1:       v20 = 20'h7FFFF;
          2:       v20 = '0;
          default: v20 = SAMPLE_W'($urandom_range(8191) - 4096);
        endcase
        return {noise[CFG_W-1:SAMPLE_W], v20};
      end
    endcase
  endfunction

  // Offer one sample item at a falling edge and hold it until accepted.
  task automatic push_item(stim_row_t r);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      smp_bus.valid = 1'b0;
      @(negedge clk);
    end
    cur_row                 = r;
    smp_bus.sample_value    = r.smp;
    smp_bus.mode            = r.mode;
    smp_bus.first_of_record = r.first;
    smp_bus.valid           = 1'b1;
    do @(posedge clk); while (!smp_bus.ready);
    items_sent++;
    if (r.first) records_sent++;
  endtask

  // Drop valid and wait until every owed result is back and the pipe is empty.
  task automatic drain_results();
    @(negedge clk);
    smp_bus.valid = 1'b0;
    while (corrected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    cfg_bus.valid = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    cfg_writes++;
  endtask

  task automatic note_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result receiver: ready changes on falling edges only. A long hold-off
  // forces the filter to back up and stall its sample input.
  // --------------------------------------------------------------------------
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_bus.ready = !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. Results are checked
  // before the new item's prediction is queued, so the order is fixed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    corrected_t want;
    logic       moved;
    if (!rst) begin
      moved = 1'b0;

      // Check the result item against the oldest prediction
      if (res_bus.valid && res_bus.ready) begin
        moved = 1'b1;
        results_seen++;
        if (res_bus.saturated) clipped_seen++;
        if (corrected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result mismatch, expected no result, actual value %0d",
                     $time, res_bus.result_value);
        end else begin
          want = corrected_q.pop_front();
          if (res_bus.result_value !== want.value)
            note_mismatch("result_value", longint'($signed(want.value)),
                          longint'(res_bus.result_value));
          if (res_bus.tail_value !== want.tail)
            note_mismatch("tail_value", longint'($signed(want.tail)),
                          longint'(res_bus.tail_value));
          if (res_bus.saturated !== want.sat)
            note_mismatch("saturated", longint'(want.sat), longint'(res_bus.saturated));
        end
      end

      // Track coefficient writes in the model copy
      if (cfg_bus.valid && cfg_bus.ready) begin
        moved = 1'b1;
        case (cfg_reg_t'(cfg_bus.index))
          REG_BETA:      beta_r      = cfg_bus.data[BETA_BITS-1:0];
          REG_ALPHA:     alpha_r     = cfg_bus.data[ALPHA_BITS-1:0];
          REG_PEDESTAL:  pedestal_r  = cfg_bus.data[SAMPLE_W-1:0];
          REG_INIT_TAIL: init_tail_r = cfg_bus.data[SAMPLE_W-1:0];
          default: ;
        endcase
      end

      // Predict the accepted sample; a hand-computed row overrides the model
      if (smp_bus.valid && smp_bus.ready) begin
        moved = 1'b1;
        want = predict_tail_correction(smp_bus.sample_value, smp_bus.mode,
                                       smp_bus.first_of_record);
        if (cur_row.typed) want = cur_row.want;
        corrected_q.push_back(want);
      end

      // Watchdog: end the run when nothing moves for too long
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results still owed",
                 $time, WATCHDOG_LIMIT, corrected_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t dir_tab [DIR_ROWS];
    stim_row_t row;
    int        tx_pct [3];
    int        rx_pct [3];
    int        sent;
    int        rec_len;
    int        recs;
    logic      rec_mode;
    logic      broken;

    // Hold every input at a known value from time zero
    rst                     = 1'b1;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = '0;
    cfg_bus.data            = '0;
    smp_bus.valid           = 1'b0;
    smp_bus.sample_value    = '0;
    smp_bus.mode            = MODE_REMOVE;
    smp_bus.first_of_record = 1'b0;
    cur_row                 = '0;

    // Sender idle share, receiver idle share, per phase
    tx_pct = '{36, 75, 0};
    rx_pct = '{75, 36, 0};

    // Directed rows. Hand-computed results where the arithmetic is trivial:
    // zero coefficients, extreme samples, clipping of either output.
    dir_tab = '{
      // reset state, no record started yet: tail stays zero
      typed_row(0,       MODE_REMOVE, 1'b0, 0,       0,       1'b0),
      typed_row(524287,  MODE_REMOVE, 1'b0, 524287,  0,       1'b0),
      typed_row(-524288, MODE_REMOVE, 1'b0, -524288, 0,       1'b0),
      typed_row(524287,  MODE_ADD,    1'b1, 524287,  0,       1'b0),
      typed_row(-524288, MODE_ADD,    1'b0, -524288, 0,       1'b0),
      // pedestal one LSB pushes the minimum sample below range
      cfg_row(REG_PEDESTAL, 24'hF00001),
      typed_row(-524288, MODE_REMOVE, 1'b1, -524288, 0,       1'b1),
      // largest initial tail: add mode clips high, remove mode clips low
      cfg_row(REG_INIT_TAIL, 24'h07FFFF),
      typed_row(524287,  MODE_ADD,    1'b1, 524287,  524287,  1'b1),
      typed_row(-524288, MODE_REMOVE, 1'b1, -524288, 524287,  1'b1),
      // most negative pedestal and initial tail
      cfg_row(REG_PEDESTAL,  24'h080000),
      cfg_row(REG_INIT_TAIL, 24'h080000),
      typed_row(-524288, MODE_ADD,    1'b1, -524288, -524288, 1'b1),
      typed_row(0,       MODE_REMOVE, 1'b0, 524287,  0,       1'b1),
      // full decay factor, tail of 1600 LSB at record start
      cfg_row(REG_PEDESTAL,  24'h000000),
      cfg_row(REG_INIT_TAIL, 24'h000640),
      cfg_row(REG_BETA,      24'hFFFFFF),
      typed_row(0,       MODE_REMOVE, 1'b1, -1600,   1600,    1'b0),
      free_row(0,        MODE_REMOVE, 1'b0),
      free_row(0,        MODE_REMOVE, 1'b0),
      free_row(0,        MODE_REMOVE, 1'b0),
      // largest feed factor drives the tail into the guarded limit
      cfg_row(REG_ALPHA, 24'h7FFFFF),
      free_row(524287,   MODE_REMOVE, 1'b0),
      free_row(524287,   MODE_REMOVE, 1'b0),
      free_row(-524288,  MODE_ADD,    1'b0),
      // most negative feed factor, no decay, modes mixed inside a record
      cfg_row(REG_ALPHA, 24'h800000),
      cfg_row(REG_BETA,  24'h000000),
      free_row(524287,   MODE_REMOVE, 1'b1),
      free_row(524287,   MODE_REMOVE, 1'b0),
      free_row(0,        MODE_ADD,    1'b0),
      free_row(-1,       MODE_REMOVE, 1'b0),
      // half decay, small feed: rounding of halves
      cfg_row(REG_BETA,  24'h008000),
      cfg_row(REG_ALPHA, 24'h001000),
      free_row(16,       MODE_ADD,    1'b1),
      free_row(16,       MODE_REMOVE, 1'b0),
      free_row(-16,      MODE_ADD,    1'b0)
    };

    // Reset once, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the first idle setting
    tx_idle_pct = tx_pct[0];
    rx_idle_pct = rx_pct[0];
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        // coefficients change only with the pipe empty
        drain_results();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        push_item(dir_tab[i]);
      end
    end

    // Random part: three idle phases, three coefficient settings in each
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = tx_pct[phase];
      rx_idle_pct = rx_pct[phase];
      for (int seg = 0; seg < 3; seg++) begin
        drain_results();
        write_reg(REG_BETA,      pick_reg_value(REG_BETA));
        write_reg(REG_ALPHA,     pick_reg_value(REG_ALPHA));
        write_reg(REG_PEDESTAL,  pick_reg_value(REG_PEDESTAL));
        write_reg(REG_INIT_TAIL, pick_reg_value(REG_INIT_TAIL));

        // Stall the receiver for a long stretch while items keep coming
        if ((phase == 0 && seg == 1) || (phase == 2 && seg == 0)) begin
          fork
            begin
              rx_hold = 1'b1;
              repeat (HOLD_CYCLES) @(posedge clk);
              rx_hold = 1'b0;
            end
          join_none
        end

        sent = 0;
        recs = 0;
        while (sent < SEG_ITEMS) begin
          // Mostly well-formed records of one mode; some broken ones lack
          // the start mark or flip mode partway through
          rec_len  = $urandom_range(24, 1);
          rec_mode = 1'($urandom_range(1));
          broken   = ($urandom_range(7) == 0);
          for (int k = 0; k < rec_len && sent < SEG_ITEMS; k++) begin
            row       = free_row(pick_sample(), rec_mode, (k == 0) && !broken);
            if (broken && $urandom_range(3) == 0) row.mode = ~rec_mode;
            // sprinkle fully random items as noise
            if ($urandom_range(9) == 0) begin
              row.smp   = sample_t'($urandom);
              row.mode  = 1'($urandom_range(1));
              row.first = 1'($urandom_range(1));
            end
            push_item(row);
            sent++;
          end
          recs++;
          // Pause the sender once per setting until all results are back
          if (recs == 2) drain_results();
        end
      end
    end

    // Wind down: let every owed result arrive and the pipe empty out
    drain_results();

    while (corrected_q.size() != 0) begin
      row.want = corrected_q.pop_front();
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: result mismatch, expected value %0d, actual none",
                 $time, row.want.value);
    end

    $display("Run covered %0d samples in %0d marked records with %0d register writes,",
             items_sent, records_sent, cfg_writes);
    $display("%0d results compared, %0d of them clipped; %0d mismatches",
             results_seen, clipped_seen, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
